[design/mbdl_pkg.sv]
// ----------------------------------------------------------------------------
// mbdl_pkg
// Shared types and constants for the multi-button debounce and lockout block.
// ----------------------------------------------------------------------------
package mbdl_pkg;

   // Number of debounced buttons and number of pins carried per item
   localparam int NUM_BUTTONS = 5;
   localparam int PIN_BITS    = 5;

   // Field widths
   localparam int MS_W     = 8;
   localparam int TIMER_W  = 16;
   localparam int PERIOD_W = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [TIMER_W-1:0]  LOCK_TIME_RST   = 16'd50;
   localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST = 8'd10;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_TIME   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_PERIOD = 1'b1;

   // Input item: one time tick
   typedef struct packed {
      logic [MS_W-1:0]     ms_passed;
      logic [PIN_BITS-1:0] pin_levels;
   } req_item_type;

   // Result item: state after the tick
   typedef struct packed {
      logic [PIN_BITS-1:0] press_events;
      logic [PIN_BITS-1:0] pressed_state;
      logic [PIN_BITS-1:0] locked_mask;
   } rsp_item_type;

   // Per-lane controls from the scan logic
   typedef struct packed {
      logic                advance;
      logic                scan;
      logic                down;
      logic [MS_W-1:0]     ms;
      logic [TIMER_W-1:0]  lock_time;
   } lane_ctrl_type;

   // Per-lane findings toward the merge stage
   typedef struct packed {
      logic event_hit;
      logic pressed;
      logic locked;
   } lane_stat_type;

endpackage

[design/mbdl_lane.sv]
// ----------------------------------------------------------------------------
// mbdl_lane
// One button: debounced state, lockout timer and press detection per tick.
// ----------------------------------------------------------------------------
module mbdl_lane
   import mbdl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   output lane_stat_type stat
);

   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic               pressed_ff, pressed_in;
   logic [TIMER_W-1:0] loaded;
   logic               change;
   logic [TIMER_W-1:0] ms_ext;

   assign ms_ext = {{(TIMER_W-MS_W){1'b0}}, ctrl.ms};

   // Take the pin level on a scan when unlocked and different
   assign change = ctrl.scan && (timer_ff == '0) && (ctrl.down != pressed_ff);

   always_comb begin
      pressed_in = change ? ctrl.down : pressed_ff;
      loaded     = change ? ctrl.lock_time : timer_ff;
      // Count down by the elapsed time, saturate at zero
      if (loaded == '0) begin
         timer_in = '0;
      end else if (loaded < ms_ext) begin
         timer_in = '0;
      end else begin
         timer_in = loaded - ms_ext;
      end
   end

   assign stat.event_hit = change && ctrl.down;
   assign stat.pressed   = pressed_in;
   assign stat.locked    = (timer_in != '0);

   // Advance state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff   <= '0;
         pressed_ff <= 1'b0;
      end else if (ctrl.advance) begin
         timer_ff   <= timer_in;
         pressed_ff <= pressed_in;
      end
   end

   // A press event only comes out of a scan of an unlocked button
   assert property (@(posedge clock) disable iff (reset)
      stat.event_hit |-> (ctrl.scan && timer_ff == '0 && !pressed_ff))
      else $error("press event without an unlocked released button");

   // An untouched locked timer never grows across an item
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.advance && timer_ff != '0) |=> (timer_ff <= $past(timer_ff)))
      else $error("locked timer grew");

   // A change of debounced state always loads the timer from a scan
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.advance && pressed_in != pressed_ff) |-> (ctrl.scan && timer_ff == '0))
      else $error("state changed while locked or outside a scan");

endmodule

[design/multi_button_debounce_lockout.sv]
// ----------------------------------------------------------------------------
// multi_button_debounce_lockout
// Debounce with lockout for active-low push buttons, advanced by time ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per tick with the elapsed milliseconds and the raw
//   pin levels. rsp channel: one item per tick with press events, debounced
//   state and lockout mask as they stand after that tick.
//   csr port: write the lockout time (index 0) or the scan period (index 1)
//   while the block is idle; writes take effect at the clock edge.
// Throughput:
//   The result of an item is registered into the output register, or into
//   the skid while the output register waits. One item per cycle is taken
//   while req_stall is low; every button has its own lane and the scan
//   counter update is one add and compare.
// Stall:
//   A two-entry output stage (output register plus skid) absorbs results
//   while rsp_stall is high; req_stall rises only when both entries are full.
// Reset:
//   Synchronous, active high. Clears the scan counter, lock timers and
//   debounced state, restores the registers to 50 ms and 10 ms, and empties
//   the output stage.
// ----------------------------------------------------------------------------
module multi_button_debounce_lockout
   import mbdl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   // Configuration
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TIMER_W-1:0]  lock_time_ff;
   logic [PERIOD_W-1:0] scan_period_ff;
   logic [TIMER_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [TIMER_W-1:0]  cnt_sum;
   logic [TIMER_W-1:0]  period_ext;
   logic                scan;
   logic                req_accept, rsp_take;

   lane_ctrl_type       lane_ctrl [NUM_BUTTONS];
   lane_stat_type       lane_stat [NUM_BUTTONS];
   rsp_item_type        next_item;

   logic                out_vld_ff, skid_vld_ff;
   rsp_item_type        out_data_ff, skid_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lock_time_ff   <= LOCK_TIME_RST;
         scan_period_ff <= SCAN_PERIOD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOCK_TIME:   lock_time_ff   <= csr_wdata[TIMER_W-1:0];
            CSR_SCAN_PERIOD: scan_period_ff <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall  = skid_vld_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_vld_ff;
   assign rsp_take   = out_vld_ff && !rsp_stall;
   assign rsp_data   = out_data_ff;

   // Scan counter: add elapsed time with wrap, subtract one period on a scan
   assign period_ext = {{(TIMER_W-PERIOD_W){1'b0}}, scan_period_ff};
   assign cnt_sum    = scan_cnt_ff + {{(TIMER_W-MS_W){1'b0}}, req_data.ms_passed};
   assign scan       = (cnt_sum >= period_ext);
   assign scan_cnt_in = scan ? (cnt_sum - period_ext) : cnt_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
      end else if (req_accept) begin
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   // One lane per button; buttons without a pin read as released
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      assign lane_ctrl[i].advance   = req_accept;
      assign lane_ctrl[i].scan      = scan;
      assign lane_ctrl[i].ms        = req_data.ms_passed;
      assign lane_ctrl[i].lock_time = lock_time_ff;
      if (i < PIN_BITS) begin : g_pin
         assign lane_ctrl[i].down = ~req_data.pin_levels[i];
      end else begin : g_nopin
         assign lane_ctrl[i].down = 1'b0;
      end

      mbdl_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lane_ctrl[i]),
         .stat  (lane_stat[i])
      );
   end

   // Merge lane findings into the result item
   for (genvar j = 0; j < PIN_BITS; j++) begin : g_merge
      if (j < NUM_BUTTONS) begin : g_btn
         assign next_item.press_events[j]  = lane_stat[j].event_hit;
         assign next_item.pressed_state[j] = lane_stat[j].pressed;
         assign next_item.locked_mask[j]   = lane_stat[j].locked;
      end else begin : g_none
         assign next_item.press_events[j]  = 1'b0;
         assign next_item.pressed_state[j] = 1'b0;
         assign next_item.locked_mask[j]   = 1'b0;
      end
   end

   // Output register and skid: control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (skid_vld_ff) begin
            if (rsp_take) begin
               skid_vld_ff <= 1'b0;
            end
         end else if (req_accept) begin
            if (out_vld_ff && !rsp_take) begin
               skid_vld_ff <= 1'b1;
            end else begin
               out_vld_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Output register and skid: payload
   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (req_accept) begin
         if (out_vld_ff && !rsp_take) begin
            skid_data_ff <= next_item;
         end else begin
            out_data_ff <= next_item;
         end
      end
   end

   // Skid only holds an item behind a waiting output
   assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid full with empty output register");

   // A parked item in the skid holds until the output drains
   assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_take) |=> (skid_vld_ff && $stable(skid_data_ff)))
      else $error("skid item lost or changed");

   // Every press event leaves its button pressed
   assert property (@(posedge clock) disable iff (reset)
      (next_item.press_events & ~next_item.pressed_state) == '0)
      else $error("press event on a released button");

   // No press events without a scan
   assert property (@(posedge clock) disable iff (reset)
      !scan |-> (next_item.press_events == '0))
      else $error("press event outside a scan");

endmodule
